// ===== sv/imm_pkg.sv =====
`timescale 1ns / 1ps
package imm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OUT_WIDTH      = 32;
  localparam int IDX_WIDTH      = 3;
  localparam int CFG_WIDTH      = 4;
  localparam int CFG_IDX_WIDTH  = 2;

  // action codes
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_COLS_B = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_WAIT  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_ERR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== sv/imm_ram.sv =====
`timescale 1ns / 1ps
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/imm_cell.sv =====
`timescale 1ns / 1ps
module imm_cell (
  input  logic                         clk,
  input  imm_pkg::cell_ctl_t           ctl,
  input  logic                         tail,
  input  logic [imm_pkg::OUT_WIDTH-1:0] neighbor,
  input  logic [imm_pkg::OUT_WIDTH-1:0] tail_in,
  output logic [imm_pkg::OUT_WIDTH-1:0] acc
);
  import imm_pkg::*;

  // accumulator: the tail cell takes the new sum, others take the neighbor
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= tail ? tail_in : neighbor;
    end
  end

endmodule

// ===== sv/integer_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Dense integer matrix multiplier C = A * B with 32-bit wrapping sums. Load items
// are taken only while idle and fill A or B in row-major order. A start with
// mismatched inner dimensions gives one error result. Otherwise each row i of C
// runs cols_a*cols_b multiply-accumulate steps, waits for the pipeline to drain
// and then gives cols_b results, each held until the output is taken. One read
// port per matrix store feeds a single multiplier into a chain of column
// accumulator cells that rotates by one cell per product.
module integer_matrix_multiply #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [imm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [imm_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       action,
  input  logic signed [31:0]               element_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [imm_pkg::OUT_WIDTH-1:0] product_value,
  output logic [imm_pkg::IDX_WIDTH-1:0]    out_row,
  output logic [imm_pkg::IDX_WIDTH-1:0]    out_col,
  output logic                             last_element,
  output logic                             dimension_error
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = $clog2(MAX_DIM + 1);
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  state_t state;

  logic [CFG_WIDTH-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [EW-1:0] ra, ca, rb, cb;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= CFG_WIDTH'(1);
      cols_a <= CFG_WIDTH'(1);
      rows_b <= CFG_WIDTH'(1);
      cols_b <= CFG_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS_A: rows_a <= cfg_data;
        REG_COLS_A: cols_a <= cfg_data;
        REG_ROWS_B: rows_b <= cfg_data;
        REG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [EW-1:0] eff_dim(input logic [CFG_WIDTH-1:0] d);
    if (d == '0) return EW'(1);
    if (32'(d) > MAX_DIM) return EW'(MAX_DIM);
    return EW'(d);
  endfunction

  assign ra = eff_dim(rows_a);
  assign ca = eff_dim(cols_a);
  assign rb = eff_dim(rows_b);
  assign cb = eff_dim(cols_b);

  logic [CW-1:0] a_size, b_size;
  assign a_size = CW'(ra) * CW'(ca);
  assign b_size = CW'(rb) * CW'(cb);

  // load counters
  logic [CW-1:0] a_count, b_count, a_idx, b_idx, a_inc, b_inc;
  assign a_idx = (a_count >= a_size) ? '0 : a_count;
  assign b_idx = (b_count >= b_size) ? '0 : b_count;
  assign a_inc = a_idx + CW'(1);
  assign b_inc = b_idx + CW'(1);

  logic in_fire, load_a, load_b, start;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_a   = in_fire && (action == ACT_LOAD_A);
  assign load_b   = in_fire && (action == ACT_LOAD_B);
  assign start    = in_fire && (action == ACT_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count <= '0;
      b_count <= '0;
    end else if (start) begin
      a_count <= '0;
      b_count <= '0;
    end else begin
      if (load_a) a_count <= (a_inc >= a_size) ? '0 : a_inc;
      if (load_b) b_count <= (b_inc >= b_size) ? '0 : b_inc;
    end
  end

  // written flags: an entry never loaded reads as zero
  logic [DEPTH-1:0] a_ok, b_ok;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ok <= '0;
      b_ok <= '0;
    end else begin
      if (load_a) a_ok[a_idx[AW-1:0]] <= 1'b1;
      if (load_b) b_ok[b_idx[AW-1:0]] <= 1'b1;
    end
  end

  // sequencer counters
  logic [IW-1:0] i_cnt, j_cnt, k_cnt;
  logic [AW-1:0] row_base, b_addr, a_addr;
  logic          j_end, k_end, i_end;
  assign j_end  = (j_cnt == IW'(cb - EW'(1)));
  assign k_end  = (k_cnt == IW'(ca - EW'(1)));
  assign i_end  = (i_cnt == IW'(ra - EW'(1)));
  assign a_addr = row_base + AW'(k_cnt);

  logic [DATA_WIDTH-1:0] a_rd, b_rd;
  imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_left (
    .clk(clk), .we(load_a), .waddr(a_idx[AW-1:0]),
    .wdata(element_value[DATA_WIDTH-1:0]), .raddr(a_addr), .rdata(a_rd)
  );
  imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_right (
    .clk(clk), .we(load_b), .waddr(b_idx[AW-1:0]),
    .wdata(element_value[DATA_WIDTH-1:0]), .raddr(b_addr), .rdata(b_rd)
  );

  // multiply pipeline
  logic s1_v, s2_v, a_ok_q, b_ok_q;
  logic [OUT_WIDTH-1:0] a_ext, b_ext, prod;
  assign a_ext = a_ok_q ? OUT_WIDTH'($signed(a_rd)) : '0;
  assign b_ext = b_ok_q ? OUT_WIDTH'($signed(b_rd)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= (state == S_MAC);
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    a_ok_q <= a_ok[a_addr];
    b_ok_q <= b_ok[b_addr];
    prod   <= a_ext * b_ext;
  end

  // accumulator chain
  logic [OUT_WIDTH-1:0] acc [MAX_DIM];
  logic [OUT_WIDTH-1:0] tail_in;
  logic                 out_free, drain_fire;
  cell_ctl_t            ctl;

  assign out_free   = !out_valid || out_ready;
  assign drain_fire = (state == S_DRAIN) && out_free;
  assign tail_in    = s2_v ? (acc[0] + prod) : '0;
  assign ctl.clear  = start;
  assign ctl.shift  = s2_v || drain_fire;

  for (genvar n = 0; n < MAX_DIM; n++) begin : g_cell
    logic [OUT_WIDTH-1:0] nb;
    if (n < MAX_DIM - 1) begin : g_mid
      assign nb = acc[n+1];
    end else begin : g_end
      assign nb = '0;
    end
    imm_cell u_cell (
      .clk(clk), .ctl(ctl), .tail(32'(n) == 32'(cb) - 1),
      .neighbor(nb), .tail_in(tail_in), .acc(acc[n])
    );
  end

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
      row_base <= '0;
      b_addr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            i_cnt <= '0;
            j_cnt <= '0;
            k_cnt <= '0;
            row_base <= '0;
            b_addr <= '0;
            state <= (ca != rb) ? S_ERR : S_MAC;
          end
        end
        S_MAC: begin
          b_addr <= b_addr + AW'(1);
          if (j_end) begin
            j_cnt <= '0;
            if (k_end) begin
              k_cnt <= '0;
              state <= S_WAIT;
            end else begin
              k_cnt <= k_cnt + IW'(1);
            end
          end else begin
            j_cnt <= j_cnt + IW'(1);
          end
        end
        S_WAIT: begin
          if (!s1_v && !s2_v) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (out_free) begin
            if (j_end) begin
              j_cnt <= '0;
              b_addr <= '0;
              if (i_end) begin
                state <= S_IDLE;
              end else begin
                i_cnt <= i_cnt + IW'(1);
                row_base <= row_base + AW'(ca);
                state <= S_MAC;
              end
            end else begin
              j_cnt <= j_cnt + IW'(1);
            end
          end
        end
        S_ERR: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain_fire || (state == S_ERR && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_fire) begin
      product_value   <= acc[0];
      out_row         <= IDX_WIDTH'(i_cnt);
      out_col         <= IDX_WIDTH'(j_cnt);
      last_element    <= i_end && j_end;
      dimension_error <= 1'b0;
    end else if (state == S_ERR && out_free) begin
      product_value   <= '0;
      out_row         <= '0;
      out_col         <= '0;
      last_element    <= 1'b1;
      dimension_error <= 1'b1;
    end
  end

  // checks
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dimension_error) |-> last_element)
    else $error("error result not marked last");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!s1_v && !s2_v))
    else $error("transfer taken while products in flight");
  a_acc_state: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (state == S_MAC || state == S_WAIT))
    else $error("accumulate outside multiply phase");
  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    drain_fire |-> !s2_v)
    else $error("drain overlaps accumulate");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import imm_pkg::*;

  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] val;
  } load_item_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
    logic        err;
  } product_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_IDLE;
  logic signed [31:0] element_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_WIDTH-1:0] product_value;
  logic [IDX_WIDTH-1:0] out_row, out_col;
  logic last_element, dimension_error;

  integer_matrix_multiply dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .product_value(product_value), .out_row(out_row), .out_col(out_col),
    .last_element(last_element), .dimension_error(dimension_error)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [31:0] left_mem [STORE_DEPTH];
  logic [31:0] right_mem [STORE_DEPTH];
  int unsigned left_cnt, right_cnt;
  logic [3:0] dim_reg [4];

  load_item_t pending_items[$];
  product_t expected_products[$];

  int mismatches = 0;
  int cycles = 0;
  int items_sent = 0;
  int starts_sent = 0;
  int products_seen = 0;
  int cfg_writes = 0;
  bit in_done = 0;
  bit quiet = 0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int unsigned dim_eff(logic [3:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(d);
  endfunction

  // write one element at the load counter, then advance it
  task automatic store_element(ref logic [31:0] mem [STORE_DEPTH], ref int unsigned cnt,
                               input int unsigned size, input logic [31:0] val);
    int unsigned idx;
    idx = cnt;
    if (idx >= size) idx = 0;
    mem[idx] = val;
    idx++;
    if (idx >= size) idx = 0;
    cnt = idx;
  endtask

  task automatic predict_gemm(input logic [1:0] act, input logic [31:0] val);
    int unsigned ra, ca, rb, cb;
    logic [31:0] acc;
    product_t p;
    ra = dim_eff(dim_reg[REG_ROWS_A]);
    ca = dim_eff(dim_reg[REG_COLS_A]);
    rb = dim_eff(dim_reg[REG_ROWS_B]);
    cb = dim_eff(dim_reg[REG_COLS_B]);
    case (act)
      ACT_LOAD_A: store_element(left_mem, left_cnt, ra * ca, val);
      ACT_LOAD_B: store_element(right_mem, right_cnt, rb * cb, val);
      ACT_START: begin
        left_cnt = 0;
        right_cnt = 0;
        if (ca != rb) begin
          p = '{value: '0, row: '0, col: '0, last: 1'b1, err: 1'b1};
          expected_products.push_back(p);
        end else begin
          for (int i = 0; i < ra; i++) begin
            for (int j = 0; j < cb; j++) begin
              acc = '0;
              for (int k = 0; k < ca; k++)
                acc += left_mem[i * ca + k] * right_mem[k * cb + j];
              p.value = acc;
              p.row = i[2:0];
              p.col = j[2:0];
              p.last = (i + 1 == ra) && (j + 1 == cb);
              p.err = 1'b0;
              expected_products.push_back(p);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      in_done = 0;
      if (!quiet && in_gap == 0 && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        action <= pending_items[0].act;
        element_value <= pending_items[0].val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall generator
  always @(negedge clk) begin
    if (!quiet && out_gap == 0 && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 3);
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst;
    end
  end

  // monitor: input transfers feed the predictor, output transfers are checked
  always @(posedge clk) begin
    product_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      if (in_valid && in_ready) begin
        predict_gemm(action, element_value);
        pending_items.pop_front();
        in_done = 1;
      end
      if (out_valid && out_ready) begin
        products_seen++;
        if (expected_products.size() == 0) begin
          report_mismatch("unexpected result", product_value, '0);
        end else begin
          e = expected_products.pop_front();
          if (product_value !== e.value) report_mismatch("product_value", product_value, e.value);
          if (out_row !== e.row) report_mismatch("out_row", 32'(out_row), 32'(e.row));
          if (out_col !== e.col) report_mismatch("out_col", 32'(out_col), 32'(e.col));
          if (last_element !== e.last)
            report_mismatch("last_element", 32'(last_element), 32'(e.last));
          if (dimension_error !== e.err)
            report_mismatch("dimension_error", 32'(dimension_error), 32'(e.err));
        end
      end
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [31:0] val);
    load_item_t it;
    it.act = act;
    it.val = val;
    pending_items.push_back(it);
    items_sent++;
    if (act == ACT_START) starts_sent++;
  endtask

  // wait for every transfer to finish, then let the block settle
  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_products.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input logic [3:0] ra, input logic [3:0] ca,
                          input logic [3:0] rb, input logic [3:0] cb);
    logic [3:0] v [4];
    v = '{ra, ca, rb, cb};
    for (int r = 0; r < 4; r++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= r[CFG_IDX_WIDTH-1:0];
      cfg_data <= v[r];
      dim_reg[r] = v[r];
      cfg_writes++;
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // full well-formed load of A and B, then start
  task automatic queue_multiply();
    int unsigned na, nb;
    na = dim_eff(dim_reg[REG_ROWS_A]) * dim_eff(dim_reg[REG_COLS_A]);
    nb = dim_eff(dim_reg[REG_ROWS_B]) * dim_eff(dim_reg[REG_COLS_B]);
    for (int i = 0; i < na; i++) push_item(ACT_LOAD_A, rand_element());
    for (int i = 0; i < nb; i++) push_item(ACT_LOAD_B, rand_element());
    push_item(ACT_START, $urandom);
  endtask

  logic [3:0] ra, inner, cb;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      left_mem[i] = '0;
      right_mem[i] = '0;
    end
    left_cnt = 0;
    right_cnt = 0;
    for (int r = 0; r < 4; r++) dim_reg[r] = 4'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset dims, zero stores, extremes, no-op action
    push_item(ACT_START, 32'h0);
    push_item(ACT_LOAD_A, 32'h8000_0000);
    push_item(ACT_LOAD_B, 32'h8000_0000);
    push_item(ACT_IDLE, 32'hffff_ffff);
    push_item(ACT_START, 32'hffff_ffff);
    push_item(ACT_LOAD_A, 32'h7fff_ffff);
    push_item(ACT_LOAD_B, 32'hffff_ffff);
    push_item(ACT_START, 32'h0);
    wait_idle();

    // register zero and above range saturate; inner mismatch gives error
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    push_item(ACT_LOAD_A, 32'h0000_0003);
    push_item(ACT_LOAD_B, 32'hffff_fffe);
    push_item(ACT_START, 32'h0);
    wait_idle();
    set_dims(4'd2, 4'd3, 4'd4, 4'd2);
    push_item(ACT_LOAD_A, 32'h5);
    push_item(ACT_START, 32'h0);
    wait_idle();
    set_dims(4'd15, 4'd15, 4'd9, 4'd8);
    queue_multiply();
    wait_idle();
    set_dims(4'd8, 4'd8, 4'd8, 4'd8);
    push_item(ACT_START, 32'h0);
    wait_idle();

    // random phases: mostly full multiplies on small shapes, some noise
    while (items_sent < 160) begin
      if (items_sent > 150) quiet = 1;
      ra = 4'($urandom_range(1, 4));
      inner = 4'($urandom_range(1, 4));
      cb = 4'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) ra = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) cb = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 5) == 0)
        set_dims(ra, inner, 4'($urandom_range(1, 4)), cb);
      else
        set_dims(ra, inner, inner, cb);
      for (int s = 0; s < 2; s++) begin
        case ($urandom_range(0, 7))
          0: push_item(ACT_IDLE, $urandom);
          1: for (int n = $urandom_range(1, 5); n > 0; n--)
               push_item(2'($urandom_range(0, 1)), rand_element());
          2: push_item(ACT_START, $urandom);
          default: queue_multiply();
        endcase
      end
      // leave a partial load so the next shape starts with stale counters
      if ($urandom_range(0, 3) == 0) push_item(2'($urandom_range(0, 1)), rand_element());
      wait_idle();
    end

    $display("covered %0d items, %0d starts, %0d results, %0d register writes",
             items_sent, starts_sent, products_seen, cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
